// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, included by utf8_stream_decoder_unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: src/utf8d_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_pkg
// Widths, byte-class limits and shared types of the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package utf8d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned PEND_W  = 2;
    localparam int unsigned OUT_W   = CP_W + LEN_W;

    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF4;

    localparam logic [LEN_W-1:0]  LEN_ONE    = 3'd1;

    typedef struct packed {
        logic [LEN_W-1:0] seq_length;
        logic [CP_W-1:0]  code_point;
    } t_result;

    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [LEN_W-1:0]  length_so_far;
    } t_dec_status;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_skid_status;

endpackage

// File: src/utf8d_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode; flags a result when a character ends.
// ---------------------------------------------------------------------------
module utf8d_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [utf8d_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_res_valid,
    output utf8d_pkg::t_result          o_res,
    output utf8d_pkg::t_dec_status      o_status
);
    import utf8d_pkg::*;

    logic [PEND_W-1:0] r_pending, n_pending;
    logic [CP_W-1:0]   r_value,   n_value;
    logic [LEN_W-1:0]  r_length,  n_length;
    logic              emit;
    logic [CP_W-1:0]   cont_value;
    logic [LEN_W-1:0]  cont_length;

    assign cont_value  = {r_value[CP_W-7:0], i_byte[5:0]};
    assign cont_length = r_length + LEN_ONE;

    always_comb begin
        n_pending = r_pending;
        n_value   = r_value;
        n_length  = r_length;
        emit      = 1'b0;
        o_res     = '0;
        if (r_pending == '0) begin
            unique case (i_byte) inside
                [LEAD2_LO:LEAD2_HI]: begin
                    n_pending = 2'd1;
                    n_value   = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                    n_length  = LEN_ONE;
                end
                [LEAD3_LO:LEAD3_HI]: begin
                    n_pending = 2'd2;
                    n_value   = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                    n_length  = LEN_ONE;
                end
                [LEAD4_LO:LEAD4_HI]: begin
                    n_pending = 2'd3;
                    n_value   = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                    n_length  = LEN_ONE;
                end
                default: begin
                    // single-byte character, including stray and invalid leads
                    emit             = 1'b1;
                    o_res.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte & ASCII_MASK};
                    o_res.seq_length = LEN_ONE;
                end
            endcase
        end else begin
            // continuation byte: shift in the low six bits, unchecked
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                emit             = 1'b1;
                o_res.code_point = cont_value;
                o_res.seq_length = cont_length;
                n_value          = '0;
                n_length         = '0;
            end else begin
                n_value  = cont_value;
                n_length = cont_length;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_value   <= '0;
            r_length  <= '0;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_value   <= n_value;
            r_length  <= n_length;
        end
    end

    assign o_res_valid            = i_accept && emit;
    assign o_status.bytes_pending = r_pending;
    assign o_status.length_so_far = r_length;

endmodule

// File: src/utf8d_skid.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8d_skid
// Output register with one skid entry so input keeps flowing under stall.
// ---------------------------------------------------------------------------
module utf8d_skid (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  utf8d_pkg::t_result     i_res,
    output logic                   o_ready,
    output logic                   o_valid,
    output utf8d_pkg::t_result     o_res,
    input  logic                   i_ready,
    output utf8d_pkg::t_skid_status o_status
);
    import utf8d_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_ready || !r_main_valid) begin
                // main slot free or draining: refill from skid first
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_valid;
                end
            end else if (i_valid && !r_skid_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (i_ready || !r_main_valid) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_valid) begin
                r_main <= i_res;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_ready             = !r_skid_valid;
    assign o_valid             = r_main_valid;
    assign o_res               = r_main;
    assign o_status.main_valid = r_main_valid;
    assign o_status.skid_valid = r_skid_valid;

endmodule

// File: src/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream in, one code point out per completed character.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while o_s_tready is high and emits the code
// point from the output register after the byte that completes a character;
// bytes that open or continue a sequence produce no output item.
// Throughput is one byte per clock, set by the per-byte state update in the
// decode stage. The output register has a one-entry skid behind it, so
// o_s_tready falls only when both hold an unclaimed result. Continuation
// bytes are not checked, and invalid lead bytes outside a sequence come out
// as one-byte characters of their low seven bits. Reset is synchronous, active low.
`include "assert_macros.svh"

module utf8_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [20:0] code_point, [23:21] seq_length
);
    import utf8d_pkg::*;

    logic         s_accept;
    logic         dec_valid;
    t_result      dec_res;
    t_dec_status  dec_status;
    t_result      out_res;
    t_skid_status skid_status;

    assign s_accept = i_s_tvalid && o_s_tready;

    utf8d_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_byte      (i_s_tdata),
        .o_res_valid (dec_valid),
        .o_res       (dec_res),
        .o_status    (dec_status)
    );

    utf8d_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dec_valid),
        .i_res    (dec_res),
        .o_ready  (o_s_tready),
        .o_valid  (o_m_tvalid),
        .o_res    (out_res),
        .i_ready  (i_m_tready),
        .o_status (skid_status)
    );

    assign o_m_tdata = {out_res.seq_length, out_res.code_point};

    // an open sequence always has a byte count, a closed one never
    `ASSERT_ALWAYS(a_len_tracks_pending, i_clk, i_rst_n,
        (dec_status.bytes_pending == '0) == (dec_status.length_so_far == '0))
    // bytes taken plus bytes pending never exceed a four-byte sequence
    `ASSERT_IMPLIES(a_len_bound, i_clk, i_rst_n, dec_status.bytes_pending != '0,
        (dec_status.length_so_far + dec_status.bytes_pending) <= 3'd4)
    // skid holds an item only behind a full main register
    `ASSERT_IMPLIES(a_skid_behind_main, i_clk, i_rst_n, skid_status.skid_valid,
        skid_status.main_valid)
    // a result never arrives with nowhere to go
    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, dec_valid,
        !skid_status.skid_valid)

endmodule

// File: test/utf8_decode_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_decode_checker
// Watches both stream channels of the UTF-8 decoder and checks its output.
// ---------------------------------------------------------------------------
// Each byte taken on the input channel runs through a local decoder state
// machine. Completed characters queue up as expected code points. Each item
// on the output channel is compared field by field with the oldest entry.
// Mismatches, unexpected items and the number of results still owed go to
// the top.
module utf8_decode_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [7:0]                 i_s_tdata,  // [7:0] in_byte
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [utf8d_pkg::OUT_W-1:0] i_m_tdata, // [20:0] code_point, [23:21] seq_length
    output int                         o_fail_count,
    output int                         o_pending
);
    import utf8d_pkg::*;

    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   cp_acc;
    logic [LEN_W-1:0]  len_acc;
    t_result           cp_expected[$];
    t_result           got;
    t_result           want;
    int                fails = 0;

    assign o_fail_count = fails;

    function automatic void note_failure(input string msg);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Advance the local decoder by one byte and queue a code point when a
    // character completes.
    task automatic decode_byte(input logic [7:0] b);
        t_result r;
        if (cont_left == '0) begin
            len_acc = LEN_ONE;
            if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                cont_left = 2'd1;
                cp_acc    = CP_W'(b[4:0]);
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                cont_left = 2'd2;
                cp_acc    = CP_W'(b[3:0]);
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                cont_left = 2'd3;
                cp_acc    = CP_W'(b[2:0]);
            end else begin
                // not a lead byte: a character of its own, low seven bits
                r.code_point = CP_W'(b & ASCII_MASK);
                r.seq_length = LEN_ONE;
                cp_expected.push_back(r);
                len_acc = '0;
            end
        end else begin
            // continuation bytes are not checked, only the low six bits count
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            len_acc   = len_acc + 1'b1;
            cont_left = cont_left - 1'b1;
            if (cont_left == '0) begin
                r.code_point = cp_acc;
                r.seq_length = len_acc;
                cp_expected.push_back(r);
                cp_acc  = '0;
                len_acc = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cont_left = '0;
            cp_acc    = '0;
            len_acc   = '0;
            cp_expected.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (cp_expected.size() == 0) begin
                    note_failure($sformatf("unexpected item code_point=%06h seq_length=%0d",
                                           got.code_point, got.seq_length));
                end else begin
                    want = cp_expected.pop_front();
                    if (got.code_point !== want.code_point) begin
                        note_failure($sformatf("code_point expected %06h got %06h",
                                               want.code_point, got.code_point));
                    end
                    if (got.seq_length !== want.seq_length) begin
                        note_failure($sformatf("seq_length expected %0d got %0d",
                                               want.seq_length, got.seq_length));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata);
            end
        end
        o_pending <= cp_expected.size();
    end

endmodule

// File: test/tb_utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Stimulus and verdict for the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
// Sends a short directed byte list (sequence length extremes, invalid lead
// bytes, unchecked continuation bytes, the largest four-byte value), then
// random characters with some noise bytes, across phases of sender idling
// and receiver stalling. The checker beside the block does the comparing.
module tb_utf8_stream_decoder_unit;
    import utf8d_pkg::*;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic [7:0]       i_s_tdata  = 8'h00;   // [7:0] in_byte
    logic             i_m_tready = 1'b0;
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;            // [20:0] code_point, [23:21] seq_length

    int               fail_count;
    int               results_owed;
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               bytes_sent = 0;
    logic [7:0]       directed_bytes[$];

    always #4 i_clk = ~i_clk;

    utf8_stream_decoder_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    utf8_decode_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_owed)
    );

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // the block takes it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_cont();
        if ($urandom_range(99) < 85) begin
            send_byte({2'b10, 6'($urandom_range(63))});
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // Hold the input idle until every expected code point has come out.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
    endtask

    task automatic send_random_char();
        int kind;
        int n_cont;
        kind   = $urandom_range(99);
        n_cont = 0;
        if (kind < 35) begin
            send_byte(8'($urandom_range(8'h7F)));
        end else if (kind < 50) begin
            send_byte(8'($urandom_range(LEAD2_HI, LEAD2_LO)));
            n_cont = 1;
        end else if (kind < 65) begin
            send_byte(8'($urandom_range(LEAD3_HI, LEAD3_LO)));
            n_cont = 2;
        end else if (kind < 80) begin
            send_byte(8'($urandom_range(LEAD4_HI, LEAD4_LO)));
            n_cont = 3;
        end else begin
            // noise: any byte, may open or break a sequence
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        end
        repeat (n_cont) send_cont();
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_bytes);
        int stop_at;
        idle_pct  = idle;
        stall_pct = stall;
        stop_at   = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_char();
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_bytes = '{
            8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF,
            8'hC2, 8'h80,
            8'hE0, 8'h80, 8'h80,
            8'hF0, 8'h80, 8'h80, 8'h80,
            8'hF4, 8'hBF, 8'hBF, 8'hBF,
            8'hDF, 8'h00,
            8'hEF, 8'hFF, 8'hC2
        };
        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        drain();

        run_phase(0, 0, 410);
        run_phase(66, 0, 410);

        // pause with a sequence open, then finish it
        send_byte(8'hE5);
        drain();
        send_byte(8'hA9);
        send_byte(8'h81);

        run_phase(0, 66, 410);
        run_phase(23, 23, 410);

        i_s_tvalid <= 1'b0;
        drain();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && results_owed == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: utf8_stream_decoder_unit.f
+incdir+src
src/utf8d_pkg.sv
src/utf8d_decode.sv
src/utf8d_skid.sv
src/utf8_stream_decoder_unit.sv
test/utf8_decode_checker.sv
test/tb_utf8_stream_decoder_unit.sv
